/* rtl/core/xcorr_pkg.sv */
// Shared types and constants for the Q15 cross-correlation block.
// Holds opcodes, register indexes, microcode word layout and step addresses.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package xcorr_pkg;

	localparam int LEN_W    = 6;
	localparam int SAMPLE_W = 16;
	localparam int DEST_W   = 6;
	localparam int ACC_W    = 32;
	localparam int OPC_W    = 2;
	localparam int CFG_IDX_W = 1;

	localparam logic [OPC_W-1:0] OP_LOAD_A = 2'd0;
	localparam logic [OPC_W-1:0] OP_LOAD_B = 2'd1;
	localparam logic [OPC_W-1:0] OP_START  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_LEN_A = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LEN_B = 1'b1;

	// microprogram step addresses
	localparam int PC_W = 4;
	localparam logic [PC_W-1:0] ST_IDLE  = 4'd0;
	localparam logic [PC_W-1:0] ST_INIT  = 4'd1;
	localparam logic [PC_W-1:0] ST_CLR   = 4'd2;
	localparam logic [PC_W-1:0] ST_TAP   = 4'd3;
	localparam logic [PC_W-1:0] ST_WAIT1 = 4'd4;
	localparam logic [PC_W-1:0] ST_WAIT2 = 4'd5;
	localparam logic [PC_W-1:0] ST_EMIT  = 4'd6;
	localparam logic [PC_W-1:0] ST_NEXT  = 4'd7;
	localparam logic [PC_W-1:0] ST_DONE  = 4'd8;

	// jump conditions
	localparam int JC_W = 3;
	localparam logic [JC_W-1:0] JC_NONE     = 3'd0;
	localparam logic [JC_W-1:0] JC_ALWAYS   = 3'd1;
	localparam logic [JC_W-1:0] JC_NO_START = 3'd2;
	localparam logic [JC_W-1:0] JC_TAP_MORE = 3'd3;
	localparam logic [JC_W-1:0] JC_OUT_BUSY = 3'd4;
	localparam logic [JC_W-1:0] JC_K_MORE   = 3'd5;

	// datapath actions of one step
	typedef struct packed {
		logic in_rdy;
		logic init;
		logic clr;
		logic tap;
		logic emit;
		logic done;
	} ctl_t;

	typedef struct packed {
		ctl_t            ctl;
		logic [JC_W-1:0] cond;
		logic [PC_W-1:0] target;
	} ucw_t;

	// datapath status for jump decisions
	typedef struct packed {
		logic start_req;
		logic tap_more;
		logic out_busy;
		logic k_more;
	} stat_t;

endpackage
`default_nettype wire

/* rtl/core/xcorr_ucode.sv */
// Microcode sequencer: step counter, control-store ROM and jump logic.
// Depends on xcorr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module xcorr_ucode
	import xcorr_pkg::*;
(
	input  wire   clk,
	input  wire   arst_n,
	input  stat_t stat,
	output ctl_t  ctl
);

	logic [PC_W-1:0] pc_q;
	ucw_t            word;
	logic            jump;

	function automatic ucw_t rom_word(input logic [PC_W-1:0] addr);
		ucw_t w;
		w = '0;
		unique case (addr)
			ST_IDLE: begin
				w.ctl.in_rdy = 1'b1;
				w.cond = JC_NO_START;
				w.target = ST_IDLE;
			end
			ST_INIT: begin
				w.ctl.init = 1'b1;
				w.cond = JC_NONE;
			end
			ST_CLR: begin
				w.ctl.clr = 1'b1;
				w.cond = JC_NONE;
			end
			ST_TAP: begin
				w.ctl.tap = 1'b1;
				w.cond = JC_TAP_MORE;
				w.target = ST_TAP;
			end
			ST_WAIT1: w.cond = JC_NONE;
			ST_WAIT2: w.cond = JC_NONE;
			ST_EMIT: begin
				w.ctl.emit = 1'b1;
				w.cond = JC_OUT_BUSY;
				w.target = ST_EMIT;
			end
			ST_NEXT: begin
				w.cond = JC_K_MORE;
				w.target = ST_CLR;
			end
			ST_DONE: begin
				w.ctl.done = 1'b1;
				w.cond = JC_ALWAYS;
				w.target = ST_IDLE;
			end
			default: begin
				w.cond = JC_ALWAYS;
				w.target = ST_IDLE;
			end
		endcase
		return w;
	endfunction

	assign word = rom_word(pc_q);
	assign ctl  = word.ctl;

	always_comb begin
		unique case (word.cond)
			JC_NONE:     jump = 1'b0;
			JC_ALWAYS:   jump = 1'b1;
			JC_NO_START: jump = !stat.start_req;
			JC_TAP_MORE: jump = stat.tap_more;
			JC_OUT_BUSY: jump = stat.out_busy;
			JC_K_MORE:   jump = stat.k_more;
			default:     jump = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else if (jump) begin
			pc_q <= word.target;
		end else begin
			pc_q <= pc_q + 1'b1;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/xcorr_datapath.sv */
// Datapath: length registers, sample memories, MAC pipeline, output register.
// Driven step by step by xcorr_ucode; depends on xcorr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module xcorr_datapath
	import xcorr_pkg::*;
#(
	parameter int MAX_LEN = 32
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  ctl_t                       ctl,
	output stat_t                      stat,
	input  wire                        in_valid,
	input  wire  [OPC_W-1:0]           opcode,
	input  wire  signed [SAMPLE_W-1:0] sample,
	input  wire                        cfg_we,
	input  wire  [CFG_IDX_W-1:0]       cfg_index,
	input  wire  [LEN_W-1:0]           cfg_wdata,
	output logic                       out_valid,
	input  wire                        out_ready,
	output logic [DEST_W-1:0]          dest_index,
	output logic signed [SAMPLE_W-1:0] corr_value,
	output logic                       last
);

	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int LW = $clog2(MAX_LEN + 1);
	localparam int NW = $clog2(2 * MAX_LEN);
	localparam int PW = $clog2(3 * MAX_LEN);

	logic [LEN_W-1:0] len_a_q, len_b_q;
	logic [LW-1:0]    a_cnt_q, b_cnt_q;
	logic [LW-1:0]    la, lb;

	logic                a_longer_q;
	logic [LW-1:0]       ll_q;
	logic [AW-1:0]       lsm1_q;
	logic [NW-1:0]       n_q, k_q, dest_q;
	logic [AW-1:0]       t_q;

	logic signed [SAMPLE_W-1:0] a_mem [MAX_LEN];
	logic signed [SAMPLE_W-1:0] b_mem [MAX_LEN];

	logic [PW-1:0] pos, rel;
	logic          in_rng;
	logic [AW-1:0] addr_a, addr_b;

	logic                       v_s1, v_s2;
	logic signed [SAMPLE_W-1:0] a_s1, b_s1;
	logic signed [ACC_W-1:0]    mul_s2;
	logic [ACC_W-1:0]           acc_q;

	logic                       out_valid_q, last_q;
	logic [NW-1:0]              out_dest_q;
	logic signed [SAMPLE_W-1:0] out_corr_q;

	logic fire, emit_fire;
	logic signed [SAMPLE_W-1:0] sat_val;

	function automatic logic [LW-1:0] clamp_len(input logic [LEN_W-1:0] len);
		logic [LW-1:0] r;
		if (len == '0) begin
			r = LW'(1);
		end else if (len > LEN_W'(MAX_LEN)) begin
			r = LW'(MAX_LEN);
		end else begin
			r = len[LW-1:0];
		end
		return r;
	endfunction

	assign la = clamp_len(len_a_q);
	assign lb = clamp_len(len_b_q);

	assign fire      = in_valid && ctl.in_rdy;
	assign emit_fire = ctl.emit && !stat.out_busy;

	assign stat.start_req = in_valid && (opcode == OP_START);
	assign stat.tap_more  = (t_q != lsm1_q);
	assign stat.out_busy  = out_valid_q && !out_ready;
	assign stat.k_more    = (k_q != n_q);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_a_q <= LEN_W'(1);
			len_b_q <= LEN_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LEN_A: len_a_q <= cfg_wdata;
				REG_LEN_B: len_b_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// load counters; drop samples past the end of the store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_cnt_q <= '0;
			b_cnt_q <= '0;
		end else if (ctl.done) begin
			a_cnt_q <= '0;
			b_cnt_q <= '0;
		end else if (fire) begin
			if (opcode == OP_LOAD_A && a_cnt_q < LW'(MAX_LEN)) begin
				a_cnt_q <= a_cnt_q + 1'b1;
			end
			if (opcode == OP_LOAD_B && b_cnt_q < LW'(MAX_LEN)) begin
				b_cnt_q <= b_cnt_q + 1'b1;
			end
		end
	end

	// tap addressing: the shorter sequence slides along the zero-padded longer one
	assign pos    = PW'(k_q) + PW'(t_q);
	assign rel    = pos - PW'(lsm1_q);
	assign in_rng = (pos >= PW'(lsm1_q)) && (rel < PW'(ll_q));
	assign addr_a = a_longer_q ? rel[AW-1:0] : t_q;
	assign addr_b = a_longer_q ? t_q : rel[AW-1:0];

	always_ff @(posedge clk) begin
		if (fire && opcode == OP_LOAD_A && a_cnt_q < LW'(MAX_LEN)) begin
			a_mem[a_cnt_q[AW-1:0]] <= sample;
		end
		a_s1 <= a_mem[addr_a];
	end

	always_ff @(posedge clk) begin
		if (fire && opcode == OP_LOAD_B && b_cnt_q < LW'(MAX_LEN)) begin
			b_mem[b_cnt_q[AW-1:0]] <= sample;
		end
		b_s1 <= b_mem[addr_b];
	end

	// run setup and counters
	always_ff @(posedge clk) begin
		if (ctl.init) begin
			a_longer_q <= (la >= lb);
			if (la >= lb) begin
				ll_q   <= la;
				lsm1_q <= AW'(lb - 1'b1);
				dest_q <= NW'(la - lb);
			end else begin
				ll_q   <= lb;
				lsm1_q <= AW'(la - 1'b1);
				dest_q <= NW'(NW'(la) + NW'(lb) - NW'(2));
			end
			n_q <= NW'(NW'(la) + NW'(lb) - NW'(1));
			k_q <= '0;
		end else if (emit_fire) begin
			k_q    <= k_q + 1'b1;
			dest_q <= a_longer_q ? dest_q + 1'b1 : dest_q - 1'b1;
		end
		if (ctl.clr) begin
			t_q <= '0;
		end else if (ctl.tap) begin
			t_q <= t_q + 1'b1;
		end
	end

	// multiply-accumulate pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= ctl.tap && in_rng;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		mul_s2 <= a_s1 * b_s1;
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(mul_s2);
		end
	end

	// shift right by 15 and saturate: fits when bits 31 and 30 agree
	assign sat_val = (acc_q[ACC_W-1] != acc_q[ACC_W-2]) ?
		(acc_q[ACC_W-1] ? 16'sh8000 : 16'sh7FFF) : $signed(acc_q[30:15]);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_dest_q <= dest_q;
			out_corr_q <= sat_val;
			last_q     <= ((k_q + 1'b1) == n_q);
		end
	end

	assign out_valid  = out_valid_q;
	assign dest_index = DEST_W'(out_dest_q);
	assign corr_value = out_corr_q;
	assign last       = last_q;

endmodule
`default_nettype wire

/* rtl/core/q15_cross_correlation.sv */
// Q15 cross-correlation: load A/B samples, then one start item emits len_a+len_b-1 items.
// A load item is taken in the idle step; a start item closes the input until the run ends
// and runs clear, taps over the shorter length, two wait steps and emit for each result.
// Throughput: one MAC per cycle in the tap step, set by the single MAC and sample memories.
// Reset (arst_n low, asynchronous): lengths return to 1, load counts and valids clear.
// Depends on xcorr_pkg, xcorr_ucode and xcorr_datapath.
`timescale 1ns / 1ps
`default_nettype none
module q15_cross_correlation
	import xcorr_pkg::*;
#(
	parameter int MAX_LEN = 32
) (
	input  wire                        clk,
	input  wire                        arst_n,
	// input items
	input  wire                        in_valid,
	output logic                       in_ready,
	input  wire  [OPC_W-1:0]           opcode,
	input  wire  signed [SAMPLE_W-1:0] sample,
	// result items
	output logic                       out_valid,
	input  wire                        out_ready,
	output logic [DEST_W-1:0]          dest_index,
	output logic signed [SAMPLE_W-1:0] corr_value,
	output logic                       last,
	// configuration writes
	input  wire                        cfg_we,
	input  wire  [CFG_IDX_W-1:0]       cfg_index,
	input  wire  [LEN_W-1:0]           cfg_wdata
);

	// The sequencer walks a nine-step program:
	//   idle   - accept items; loads write the stores, a start item jumps on
	//   init   - latch clamped lengths, pick the longer sequence, set first dest
	//   clear  - zero the accumulator and the tap counter
	//   tap    - issue one tap per cycle until the shorter length is used up;
	//            taps that fall on the zero padding are dropped
	//   wait x2 - drain the memory read stage and the multiplier stage
	//   emit   - hold until the output register is free, then load it
	//   next   - loop back to clear while results remain
	//   done   - clear load counts and return to idle
	// The output register lets the sequencer start the next result while the
	// previous one waits for out_ready.

	ctl_t  ctl;
	stat_t stat;

	xcorr_ucode u_ucode (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	xcorr_datapath #(
		.MAX_LEN (MAX_LEN)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.stat       (stat),
		.in_valid   (in_valid),
		.opcode     (opcode),
		.sample     (sample),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.dest_index (dest_index),
		.corr_value (corr_value),
		.last       (last)
	);

	// accept items only in the idle step
	assign in_ready = ctl.in_rdy;

endmodule
`default_nettype wire

/* rtl/core/xcorr_checker.sv */
// Port-level checks for q15_cross_correlation, attached with a bind.
// Depends on xcorr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module xcorr_checker
	import xcorr_pkg::*;
(
	input wire                 clk,
	input wire                 arst_n,
	input wire                 in_valid,
	input wire                 in_ready,
	input wire [OPC_W-1:0]     opcode,
	input wire                 out_valid,
	input wire                 out_ready,
	input wire [DEST_W-1:0]    dest_index,
	input wire [SAMPLE_W-1:0]  corr_value,
	input wire                 last
);

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			out_valid && $stable(dest_index) && $stable(corr_value) && $stable(last))
		else $error("result item changed while stalled");

	// a start item closes the input right after it is accepted
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && opcode == OP_START |=> !in_ready)
		else $error("input reopened right after start");

	// a result that is not the last one means the run is still going
	a_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> !in_ready)
		else $error("input open in the middle of a run");

	// items other than start produce no result
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && opcode != OP_START && !out_valid |=> !out_valid)
		else $error("result appeared without a start item");

endmodule

bind q15_cross_correlation xcorr_checker u_xcorr_checker (.*);
`default_nettype wire
